// File: design/fau_pkg.sv
// Shared types and constants for the fraction arithmetic unit.
package fau_pkg;

  localparam int unsigned OPERAND_BITS_DEF = 16;
  localparam int unsigned OP_W             = 3;
  localparam int unsigned RES_NUM_W        = 32;
  localparam int unsigned RES_DEN_W        = 30;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_EQ  = 3'd3,
    OP_NE  = 3'd4,
    OP_GE  = 3'd5,
    OP_LE  = 3'd6,
    OP_RED = 3'd7
  } op_e;

endpackage

// File: design/fau_if.sv
// Request and result channel interfaces of the fraction arithmetic unit.
interface fau_req_if import fau_pkg::*; #(
  parameter int unsigned OPERAND_BITS = OPERAND_BITS_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic        [OP_W-1:0]         req_type;
  logic signed [OPERAND_BITS-1:0] a_num;
  logic        [OPERAND_BITS-2:0] a_den;
  logic signed [OPERAND_BITS-1:0] b_num;
  logic        [OPERAND_BITS-2:0] b_den;

  modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

interface fau_res_if import fau_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [RES_NUM_W-1:0] res_num;
  logic        [RES_DEN_W-1:0] res_den;
  logic                        cmp_true;
  logic                        bad_den;

  modport source (output valid, res_num, res_den, cmp_true, bad_den, input ready);
  modport sink   (input valid, res_num, res_den, cmp_true, bad_den, output ready);
endinterface

// File: design/fraction_arithmetic_unit.sv
// Sequence from request transfer to result valid: add/sub/mul/compare pass through ST_MUL1,
// ST_MUL2, ST_MUL3 and ST_FIN; a zero denominator goes straight to ST_FIN. Reduce: a binary
// gcd loop, two restoring divides of OPERAND_BITS quotient bits each, and the output state.
// One request in flight; the next is taken the cycle after the result is loaded, and a
// stalled result holds the sequencer in its last state until the result is taken.
// Reset (rst_ni low, async) returns the sequencer to idle and drops result valid.
module fraction_arithmetic_unit import fau_pkg::*; #(
  parameter int unsigned OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fau_req_if.sink   req_i,
  fau_res_if.source res_o
);

  localparam int unsigned W  = OPERAND_BITS;
  localparam int unsigned MW = W + 1;
  localparam int unsigned PW = 2 * MW;
  localparam int unsigned CW = $clog2(W);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MUL1 = 8'b0000_0010,
    ST_MUL2 = 8'b0000_0100,
    ST_MUL3 = 8'b0000_1000,
    ST_GCD  = 8'b0001_0000,
    ST_DIVN = 8'b0010_0000,
    ST_DIVD = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  op_e                     op_q, op_d;
  logic signed [W-1:0]     an_q, an_d, bn_q, bn_d;
  logic        [W-2:0]     ad_q, ad_d, bd_q, bd_d;
  logic signed [PW-1:0]    l_q, l_d, r_q, r_d;
  logic        [W-1:0]     x_q, x_d, y_q, y_d, mag_q, mag_d;
  logic                    neg_q, neg_d;
  logic        [CW-1:0]    k_q, k_d, cnt_q, cnt_d;
  logic        [W-2:0]     g_q, g_d, rem_q, rem_d;
  logic        [W-1:0]     quo_q, quo_d;

  logic        [RES_NUM_W-1:0] rn_q, rn_d, on_q, on_d;
  logic        [RES_DEN_W-1:0] rd_q, rd_d, od_q, od_d;
  logic                        ct_q, ct_d, bad_q, bad_d, oc_q, oc_d, ob_q, ob_d;
  logic                        ov_q, ov_d;

  logic                    accept;
  logic                    in_bad;
  logic        [W-1:0]     in_mag;
  logic                    unit_den;
  logic signed [MW-1:0]    an_x, bn_x, ad_x, bd_x, one_x;
  logic signed [MW-1:0]    mul_a, mul_b;
  logic signed [PW-1:0]    prod;
  logic signed [PW:0]      sum_w;
  logic        [W-1:0]     sub_a, sub_b;
  logic        [W:0]       diff;
  logic                    borrow;
  logic        [W-1:0]     g_full;
  logic        [W-1:0]     q_next;
  logic                    cmp_res;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  assign in_bad = (op_e'(req_i.req_type) == OP_RED) ? (req_i.a_den == '0)
                : ((req_i.a_den == '0) || (req_i.b_den == '0));
  assign in_mag = req_i.a_num[W-1] ? (~req_i.a_num + W'(1)) : req_i.a_num;

  // Equal denominators on add/sub: multiply by one so the shared denominator is kept.
  assign unit_den = ((op_q == OP_ADD) || (op_q == OP_SUB)) && (ad_q == bd_q);
  assign an_x  = {an_q[W-1], an_q};
  assign bn_x  = {bn_q[W-1], bn_q};
  assign ad_x  = {2'b00, ad_q};
  assign bd_x  = {2'b00, bd_q};
  assign one_x = MW'(1);

  assign prod   = mul_a * mul_b;
  assign sum_w  = (op_q == OP_SUB) ? (l_q - r_q) : (l_q + r_q);
  assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow = diff[W];
  assign g_full = y_q << k_q;
  assign q_next = {quo_q[W-2:0], ~borrow};

  always_comb begin
    unique case (op_q)
      OP_EQ:   cmp_res = (l_q == r_q);
      OP_NE:   cmp_res = (l_q != r_q);
      OP_GE:   cmp_res = (l_q >= r_q);
      OP_LE:   cmp_res = (l_q <= r_q);
      default: cmp_res = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    op_d = op_q; an_d = an_q; bn_d = bn_q; ad_d = ad_q; bd_d = bd_q;
    l_d = l_q; r_d = r_q;
    x_d = x_q; y_d = y_q; mag_d = mag_q; neg_d = neg_q; k_d = k_q;
    g_d = g_q; rem_d = rem_q; quo_d = quo_q; cnt_d = cnt_q;
    rn_d = rn_q; rd_d = rd_q; ct_d = ct_q; bad_d = bad_q;
    on_d = on_q; od_d = od_q; oc_d = oc_q; ob_d = ob_q;
    ov_d = ov_q;
    mul_a = an_x;
    mul_b = bd_x;
    sub_a = x_q;
    sub_b = y_q;

    if (ov_q && res_o.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d  = op_e'(req_i.req_type);
          an_d  = req_i.a_num;
          ad_d  = req_i.a_den;
          bn_d  = req_i.b_num;
          bd_d  = req_i.b_den;
          rn_d  = '0;
          rd_d  = '0;
          ct_d  = 1'b0;
          bad_d = in_bad;
          mag_d = in_mag;
          neg_d = req_i.a_num[W-1];
          x_d   = in_mag;
          y_d   = {1'b0, req_i.a_den};
          k_d   = '0;
          if (in_bad) begin
            state_d = ST_FIN;
          end else if (op_e'(req_i.req_type) == OP_RED) begin
            state_d = ST_GCD;
          end else begin
            state_d = ST_MUL1;
          end
        end
      end
      ST_MUL1: begin
        mul_a   = an_x;
        mul_b   = (op_q == OP_MUL) ? bn_x : (unit_den ? one_x : bd_x);
        l_d     = prod;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        mul_a   = bn_x;
        mul_b   = unit_den ? one_x : ad_x;
        r_d     = prod;
        state_d = ST_MUL3;
      end
      ST_MUL3: begin
        mul_a = ad_x;
        mul_b = unit_den ? one_x : bd_x;
        case (op_q)
          OP_ADD, OP_SUB: begin
            rn_d = RES_NUM_W'(sum_w);
            rd_d = RES_DEN_W'(prod);
          end
          OP_MUL: begin
            rn_d = RES_NUM_W'(l_q);
            rd_d = RES_DEN_W'(prod);
          end
          default: begin
            ct_d = cmp_res;
          end
        endcase
        state_d = ST_FIN;
      end
      ST_GCD: begin
        // binary gcd: common factors of two go to k, odd pairs subtract or swap
        sub_a = x_q;
        sub_b = y_q;
        if (x_q == '0) begin
          g_d     = g_full[W-2:0];
          quo_d   = mag_q;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = ST_DIVN;
        end else if (!x_q[0] && !y_q[0]) begin
          x_d = x_q >> 1;
          y_d = y_q >> 1;
          k_d = k_q + CW'(1);
        end else if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (!borrow) begin
          x_d = diff[W:1];
        end else begin
          x_d = y_q;
          y_d = x_q;
        end
      end
      ST_DIVN, ST_DIVD: begin
        // restoring divide, one quotient bit per cycle
        sub_a = {rem_q, quo_q[W-1]};
        sub_b = {1'b0, g_q};
        rem_d = borrow ? sub_a[W-2:0] : diff[W-2:0];
        quo_d = q_next;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(W - 1)) begin
          cnt_d = '0;
          if (state_q == ST_DIVN) begin
            rn_d    = neg_q ? (-RES_NUM_W'(q_next)) : RES_NUM_W'(q_next);
            quo_d   = {1'b0, ad_q};
            rem_d   = '0;
            state_d = ST_DIVD;
          end else begin
            rd_d    = RES_DEN_W'(q_next);
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (!ov_q || res_o.ready) begin
          on_d    = rn_q;
          od_d    = rd_q;
          oc_d    = ct_q;
          ob_d    = bad_q;
          ov_d    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    an_q  <= an_d;
    bn_q  <= bn_d;
    ad_q  <= ad_d;
    bd_q  <= bd_d;
    l_q   <= l_d;
    r_q   <= r_d;
    x_q   <= x_d;
    y_q   <= y_d;
    mag_q <= mag_d;
    neg_q <= neg_d;
    k_q   <= k_d;
    g_q   <= g_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
    rn_q  <= rn_d;
    rd_q  <= rd_d;
    ct_q  <= ct_d;
    bad_q <= bad_d;
    on_q  <= on_d;
    od_q  <= od_d;
    oc_q  <= oc_d;
    ob_q  <= ob_d;
  end

  assign res_o.valid    = ov_q;
  assign res_o.res_num  = on_q;
  assign res_o.res_den  = od_q;
  assign res_o.cmp_true = oc_q;
  assign res_o.bad_den  = ob_q;

endmodule

// File: design/fau_checker.sv
// Port-level assertions for the fraction arithmetic unit, with its bind.
module fau_checker import fau_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [RES_NUM_W-1:0] res_num_i,
  input logic [RES_DEN_W-1:0] res_den_i,
  input logic                 cmp_true_i,
  input logic                 bad_den_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(res_num_i)
      && $stable(res_den_i) && $stable(cmp_true_i) && $stable(bad_den_i))
    else $error("result changed while stalled");

  // one request at a time: busy right after a request transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while busy");

  // zero denominator clears every other result field
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && bad_den_i |-> res_num_i == '0 && res_den_i == '0 && !cmp_true_i)
    else $error("bad denominator with nonzero result");

endmodule

bind fraction_arithmetic_unit fau_checker u_fau_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .res_num_i   (res_o.res_num),
  .res_den_i   (res_o.res_den),
  .cmp_true_i  (res_o.cmp_true),
  .bad_den_i   (res_o.bad_den)
);

// File: sim/fraction_result_checker.sv
// Watches both channels of the fraction unit, predicts each result and compares it.
`timescale 1ns / 100ps

module fraction_result_checker import fau_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  fau_req_if   req_i,
  fau_res_if   res_i,
  output int   mismatch_cnt_o,
  output int   pending_cnt_o
);

  localparam int unsigned NB = OPERAND_BITS_DEF;

  typedef struct packed {
    logic signed [RES_NUM_W-1:0] num;
    logic        [RES_DEN_W-1:0] den;
    logic                        cmp;
    logic                        bad;
  } frac_res_t;

  frac_res_t expected_fracs[$];
  int        mismatch_cnt = 0;
  int        pending_cnt  = 0;

  assign mismatch_cnt_o = mismatch_cnt;
  assign pending_cnt_o  = pending_cnt;

  function automatic frac_res_t predict_fraction_result(
    input op_e                    op,
    input logic signed [NB-1:0]   a_num,
    input logic        [NB-2:0]   a_den,
    input logic signed [NB-1:0]   b_num,
    input logic        [NB-2:0]   b_den
  );
    frac_res_t r;
    longint    an, bn, ad, bd, x, y, t, mag, w, lhs, rhs;
    r  = '0;
    an = a_num;
    bn = b_num;
    ad = a_den;
    bd = b_den;
    if (op == OP_RED) begin
      // reduce only looks at the first operand
      if (ad == 0) begin
        r.bad = 1'b1;
      end else begin
        mag = (an < 0) ? -an : an;
        x   = mag;
        y   = ad;
        while (y != 0) begin
          t = x % y;
          x = y;
          y = t;
        end
        w     = (an < 0) ? -(mag / x) : (mag / x);
        r.num = w[RES_NUM_W-1:0];
        w     = ad / x;
        r.den = w[RES_DEN_W-1:0];
      end
    end else if (ad == 0 || bd == 0) begin
      r.bad = 1'b1;
    end else begin
      case (op)
        OP_ADD, OP_SUB: begin
          if (ad == bd) begin
            x = an;
            y = bn;
            w = ad;
          end else begin
            x = an * bd;
            y = bn * ad;
            w = ad * bd;
          end
          r.den = w[RES_DEN_W-1:0];
          w     = (op == OP_ADD) ? x + y : x - y;
          r.num = w[RES_NUM_W-1:0];
        end
        OP_MUL: begin
          w     = an * bn;
          r.num = w[RES_NUM_W-1:0];
          w     = ad * bd;
          r.den = w[RES_DEN_W-1:0];
        end
        default: begin
          lhs = an * bd;
          rhs = bn * ad;
          case (op)
            OP_EQ:   r.cmp = (lhs == rhs);
            OP_NE:   r.cmp = (lhs != rhs);
            OP_GE:   r.cmp = (lhs >= rhs);
            default: r.cmp = (lhs <= rhs);
          endcase
        end
      endcase
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    frac_res_t got, want;
    if (rst_ni) begin
      if (req_i.valid && req_i.ready) begin
        expected_fracs.push_back(predict_fraction_result(op_e'(req_i.req_type),
          req_i.a_num, req_i.a_den, req_i.b_num, req_i.b_den));
      end
      if (res_i.valid && res_i.ready) begin
        got.num = res_i.res_num;
        got.den = res_i.res_den;
        got.cmp = res_i.cmp_true;
        got.bad = res_i.bad_den;
        if (expected_fracs.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: unexpected result: num %0d den %0d cmp %0b bad %0b",
                     $realtime, got.num, got.den, got.cmp, got.bad);
        end else begin
          want = expected_fracs.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("%0t: mismatch exp %0d/%0d cmp %0b bad %0b got %0d/%0d cmp %0b bad %0b",
                       $realtime, want.num, want.den, want.cmp, want.bad,
                       got.num, got.den, got.cmp, got.bad);
          end
        end
      end
      pending_cnt = expected_fracs.size();
    end
  end

endmodule

// File: sim/fraction_arithmetic_unit_tb.sv
// Stimulus, clock, reset and verdict for the fraction arithmetic unit.
`timescale 1ns / 100ps

module fraction_arithmetic_unit_tb;
  import fau_pkg::*;

  localparam int unsigned NB = OPERAND_BITS_DEF;
  localparam logic signed [NB-1:0] NUM_MIN = {1'b1, {(NB-1){1'b0}}};
  localparam logic signed [NB-1:0] NUM_MAX = {1'b0, {(NB-1){1'b1}}};
  localparam logic        [NB-2:0] DEN_MAX = '1;
  localparam int                   HOLD_CYCLES = 300;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   mismatch_cnt;
  int   pending_cnt;
  int   src_idle_pct  = 0;
  int   snk_stall_pct = 0;
  int   hold_seq      = 0;

  fau_req_if #(.OPERAND_BITS(NB)) req_if ();
  fau_res_if                      res_if ();

  fraction_arithmetic_unit #(.OPERAND_BITS(NB)) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  fraction_result_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_if),
    .res_i          (res_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("fraction_arithmetic_unit_tb: errors");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int seen_seq;
    int hold_left;
    seen_seq  = 0;
    hold_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  function automatic logic signed [NB-1:0] rand_num();
    case ($urandom_range(9))
      0:       return NUM_MIN;
      1:       return NUM_MAX;
      2:       return '0;
      3, 4:    return NB'(int'($urandom_range(40)) - 20);
      default: return NB'($urandom);
    endcase
  endfunction

  function automatic logic [NB-2:0] rand_den();
    case ($urandom_range(19))
      0:          return '0;
      1:          return (NB-1)'(1);
      2:          return DEN_MAX;
      3, 4, 5, 6: return (NB-1)'($urandom_range(1, 30));
      default:    return (NB-1)'($urandom);
    endcase
  endfunction

  task automatic send_frac_req(input op_e op,
                               input logic signed [NB-1:0] an, input logic [NB-2:0] ad,
                               input logic signed [NB-1:0] bn, input logic [NB-2:0] bd);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= op;
    req_if.a_num    <= an;
    req_if.a_den    <= ad;
    req_if.b_num    <= bn;
    req_if.b_den    <= bd;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic send_random_frac();
    op_e                  op;
    logic signed [NB-1:0] an, bn;
    logic        [NB-2:0] ad, bd;
    int                   m, d, k;
    op = op_e'($urandom_range(7));
    an = rand_num();
    bn = rand_num();
    ad = rand_den();
    bd = ($urandom_range(3) == 0) ? ad : rand_den();
    if (op == OP_RED && $urandom_range(1) == 1) begin
      // shared factor so the gcd has real work to do
      k  = $urandom_range(1, 200);
      m  = int'($urandom_range(300)) - 150;
      an = NB'(m * k);
      ad = (NB-1)'(int'($urandom_range(1, 150)) * k);
    end else if (op inside {OP_EQ, OP_NE, OP_GE, OP_LE} && $urandom_range(2) == 0) begin
      // b is a scaled copy of a, so the two fractions are equal
      m  = int'($urandom_range(2000)) - 1000;
      d  = $urandom_range(1, 1000);
      k  = $urandom_range(1, 30);
      an = NB'(m);
      ad = (NB-1)'(d);
      bn = NB'(m * k);
      bd = (NB-1)'(d * k);
    end
    send_frac_req(op, an, ad, bn, bd);
  endtask

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    idle_tab  = '{0, 55, 0, 28};
    stall_tab = '{0, 0, 55, 28};
    rst_ni          <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.req_type <= OP_ADD;
    req_if.a_num    <= '0;
    req_if.a_den    <= '0;
    req_if.b_num    <= '0;
    req_if.b_den    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_frac_req(OP_ADD, NUM_MAX, DEN_MAX, NUM_MAX, DEN_MAX - 1'b1);
    send_frac_req(OP_ADD, NUM_MIN, 5, NUM_MIN, 5);
    send_frac_req(OP_ADD, NUM_MAX, DEN_MAX, NUM_MIN, DEN_MAX);
    send_frac_req(OP_SUB, NUM_MIN, DEN_MAX, NUM_MAX, 1);
    send_frac_req(OP_SUB, 7, 3, 9, 3);
    send_frac_req(OP_SUB, 0, 1, 0, 1);
    send_frac_req(OP_MUL, NUM_MIN, DEN_MAX, NUM_MIN, DEN_MAX);
    send_frac_req(OP_MUL, NUM_MAX, 1, NUM_MIN, DEN_MAX);
    send_frac_req(OP_EQ, 1, 2, 2, 4);
    send_frac_req(OP_EQ, 1, 2, 1, 3);
    send_frac_req(OP_NE, 1, 2, 2, 4);
    send_frac_req(OP_NE, -1, 3, 1, 3);
    send_frac_req(OP_GE, 1, 3, 1, 3);
    send_frac_req(OP_GE, NUM_MIN, 1, NUM_MAX, 1);
    send_frac_req(OP_LE, NUM_MAX, 1, NUM_MIN, DEN_MAX);
    send_frac_req(OP_LE, 2, 4, 1, 2);
    send_frac_req(OP_RED, 12, 18, 0, 0);
    send_frac_req(OP_RED, NUM_MIN, DEN_MAX, 3, 3);
    send_frac_req(OP_RED, NUM_MIN, 16384, 0, 1);
    // zero numerator reduces to 0/1
    send_frac_req(OP_RED, 0, DEN_MAX, 1, 1);
    send_frac_req(OP_RED, -30, 0, 1, 1);
    // reduce ignores the second denominator
    send_frac_req(OP_RED, 5, 10, NUM_MAX, 0);
    send_frac_req(OP_ADD, 3, 0, 4, 5);
    send_frac_req(OP_MUL, 3, 4, 4, 0);
    send_frac_req(OP_EQ, 0, 0, 0, 0);

    for (int p = 0; p < 4; p++) begin
      src_idle_pct  = idle_tab[p];
      snk_stall_pct = stall_tab[p];
      if (p == 0)
        hold_seq++;
      repeat (500) send_random_frac();
    end

    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_cnt == 0)
      $display("fraction_arithmetic_unit_tb: clean");
    else
      $display("fraction_arithmetic_unit_tb: errors");
    $finish;
  end

endmodule
